// ===== rtl/ple_pkg.sv =====
// Package for the positional list engine: opcodes, status codes and the
// command that the controller broadcasts to every list cell.
// Depends on nothing; used by ple_cell and positional_list_engine.
package ple_pkg;

   localparam int unsigned DefaultDepth = 16;
   localparam int unsigned ValueWidth   = 32;
   localparam int unsigned OpcodeWidth  = 3;
   localparam int unsigned PosWidth     = 5;
   localparam int unsigned LengthWidth  = 5;
   localparam int unsigned StatusWidth  = 2;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_APPEND  = 3'd0,
      OP_PREPEND = 3'd1,
      OP_INSERT  = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_READ    = 3'd4
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type                   kind;
      logic signed [ValueWidth-1:0] value;
   } cell_cmd_type;

endpackage

// ===== rtl/ple_cell.sv =====
// One storage cell of the positional list: holds one element and takes
// its next value from itself, its left neighbor, its right neighbor or the
// broadcast value. Depends on ple_pkg.
module ple_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned IW    = 4
) (
   input  logic                                    clock,
   input  ple_pkg::cell_cmd_type                   cmd,
   input  logic [IW-1:0]                           cmd_idx,
   input  logic signed [ple_pkg::ValueWidth-1:0]   left_data,
   input  logic signed [ple_pkg::ValueWidth-1:0]   right_data,
   output logic signed [ple_pkg::ValueWidth-1:0]   data_out,
   output logic [ple_pkg::ValueWidth-1:0]          tap_out
);

   localparam logic [IW-1:0] MyIndex = IW'(INDEX);

   logic signed [ple_pkg::ValueWidth-1:0] data_ff;
   logic signed [ple_pkg::ValueWidth-1:0] data_in;
   logic                                  hit;

   assign hit = (cmd_idx == MyIndex);

   always_comb begin
      data_in = data_ff;
      unique case (cmd.kind)
         ple_pkg::CELL_INSERT: begin
            // Cells above the insertion point move up by one place.
            if (hit) begin
               data_in = cmd.value;
            end else if (MyIndex > cmd_idx) begin
               data_in = left_data;
            end
         end
         ple_pkg::CELL_REMOVE: begin
            // Cells at and above the gap pull in their right neighbor.
            if (MyIndex >= cmd_idx) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign tap_out  = hit ? data_ff : '0;

endmodule

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: request decode, length count,
// the row of list cells and the registered response.
// Depends on ple_pkg and ple_cell.

// The engine keeps an ordered list of up to DEPTH signed 32-bit elements in
// a row of cells and answers every request item with one response item
// (read or removed value, new length, status). Every cell shifts, loads or
// holds in the cycle the item is accepted, and the response is registered,
// so one item can be accepted per clock as long as the response side keeps
// taking items. A read or remove picks the addressed cell through an AND-OR
// selection over all cells in that cycle.
// No request item is taken while reset is high.
module positional_list_engine #(
   parameter int unsigned DEPTH = ple_pkg::DefaultDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: opcode[2:0], value[34:3], position[39:35].
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: read_value[31:0], length[36:32], status[38:37], zero pad[39].
   output logic [39:0] rsp_tdata
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned WW = CW + ple_pkg::PosWidth;
   localparam logic [WW-1:0] DepthW = WW'(DEPTH);
   localparam int unsigned VW = ple_pkg::ValueWidth;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic [39:0]           rsp_data_ff;
   logic [39:0]           rsp_data_in;
   logic                  accept;

   ple_pkg::opcode_type   op;
   logic signed [VW-1:0]  value;
   logic [WW-1:0]         pos_ext;
   logic [WW-1:0]         cnt_ext;
   logic [WW-1:0]         ins_ext;
   logic [WW-1:0]         new_cnt_ext;
   ple_pkg::cell_cmd_type cmd;
   logic [IW-1:0]         cmd_idx;
   ple_pkg::status_type   status;
   logic [VW-1:0]         rd_value;
   logic [VW-1:0]         sel_value;

   logic signed [VW-1:0]  cell_data [DEPTH];
   logic [VW-1:0]         cell_tap  [DEPTH];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);

   assign op      = ple_pkg::opcode_type'(req_tdata[2:0]);
   assign value   = req_tdata[34:3];
   assign pos_ext = WW'(req_tdata[39:35]);
   assign cnt_ext = WW'(count_ff);

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_value = sel_value | cell_tap[i];
      end
   end

   always_comb begin
      unique case (op)
         ple_pkg::OP_APPEND:  ins_ext = cnt_ext;
         ple_pkg::OP_PREPEND: ins_ext = '0;
         default:             ins_ext = pos_ext;
      endcase
   end

   always_comb begin
      cmd.kind  = ple_pkg::CELL_HOLD;
      cmd.value = value;
      cmd_idx   = pos_ext[IW-1:0];
      status    = ple_pkg::ST_DONE;
      rd_value  = '0;
      count_in  = count_ff;
      unique case (op)
         ple_pkg::OP_APPEND, ple_pkg::OP_PREPEND, ple_pkg::OP_INSERT: begin
            cmd_idx = ins_ext[IW-1:0];
            // The range check comes before the full-list check.
            if (ins_ext > cnt_ext) begin
               status = ple_pkg::ST_RANGE;
            end else if (cnt_ext >= DepthW) begin
               status = ple_pkg::ST_FULL;
            end else begin
               cmd.kind = ple_pkg::CELL_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               cmd.kind = ple_pkg::CELL_REMOVE;
               rd_value = sel_value;
               count_in = count_ff - CW'(1);
            end
         end
         ple_pkg::OP_READ: begin
            if (pos_ext >= cnt_ext) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               rd_value = sel_value;
            end
         end
         default: begin
            status = ple_pkg::ST_DONE;
         end
      endcase
      if (!accept) begin
         cmd.kind = ple_pkg::CELL_HOLD;
         count_in = count_ff;
      end
   end

   // The reported length is the count masked to the field width.
   assign new_cnt_ext = WW'(count_in);
   assign rsp_data_in = {1'b0, status, new_cnt_ext[ple_pkg::LengthWidth-1:0], rd_value};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VW-1:0] left_d;
      logic signed [VW-1:0] right_d;
      if (g == 0) begin : g_first
         assign left_d = value;
      end else begin : g_mid_l
         assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_d = cell_data[g];
      end else begin : g_mid_r
         assign right_d = cell_data[g+1];
      end
      ple_cell #(
         .INDEX (g),
         .IW    (IW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cmd_idx    (cmd_idx),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[g]),
         .tap_out    (cell_tap[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ext <= DepthW)
      else $error("list count exceeds depth");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("list count changed without an accepted item");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1)
                  || count_ff == $past(count_ff) - CW'(1)))
      else $error("list count moved by more than one");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[38:37] == ple_pkg::ST_FULL) |-> cnt_ext == DepthW)
      else $error("full status reported while list not full");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no response");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for positional_list_engine: random and directed list operations on
// the stream ports, checked item by item against a predictor of the list.
// Depends on ple_pkg and the positional_list_engine RTL.
module tb;

   localparam int unsigned Depth      = ple_pkg::DefaultDepth;
   localparam int unsigned OpW        = ple_pkg::OpcodeWidth;
   localparam int unsigned PosW       = ple_pkg::PosWidth;
   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DrainWait  = 8;

   typedef struct {
      logic signed [ple_pkg::ValueWidth-1:0]  value;
      logic        [ple_pkg::LengthWidth-1:0] len;
      logic        [ple_pkg::StatusWidth-1:0] status;
   } list_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Fields from bit 0: opcode[2:0], value[34:3], position[39:35].
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Fields from bit 0: read_value[31:0], length[36:32], status[38:37], zero pad[39].
   logic [39:0] rsp_tdata;

   // Predicted contents of the list.
   logic signed [ple_pkg::ValueWidth-1:0] stored [Depth];
   int unsigned                           stored_len = 0;

   list_reply_type awaited [$];
   int unsigned faults = 0;
   int unsigned cycles = 0;
   int unsigned stall_left = 0;
   bit          quiet = 1'b0;

   positional_list_engine #(.DEPTH(Depth)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Applies one operation to the predicted list and returns the reply it causes.
   function automatic list_reply_type apply_list_op(logic [OpW-1:0] op,
                                                    logic signed [ple_pkg::ValueWidth-1:0] val,
                                                    logic [PosW-1:0] pos);
      list_reply_type r;
      int unsigned slot;
      int unsigned k;
      r.value  = '0;
      r.status = ple_pkg::ST_DONE;
      case (op)
         ple_pkg::OP_APPEND, ple_pkg::OP_PREPEND, ple_pkg::OP_INSERT: begin
            if (op == ple_pkg::OP_APPEND)
               slot = stored_len;
            else if (op == ple_pkg::OP_PREPEND)
               slot = 0;
            else
               slot = pos;
            // The index check takes priority over the full-list check.
            if (slot > stored_len)
               r.status = ple_pkg::ST_RANGE;
            else if (stored_len >= Depth)
               r.status = ple_pkg::ST_FULL;
            else begin
               for (k = stored_len; k > slot; k--)
                  stored[k] = stored[k-1];
               stored[slot] = val;
               stored_len++;
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (pos >= stored_len)
               r.status = ple_pkg::ST_RANGE;
            else begin
               r.value = stored[pos];
               for (k = pos; k + 1 < stored_len; k++)
                  stored[k] = stored[k+1];
               stored_len--;
            end
         end
         ple_pkg::OP_READ: begin
            if (pos >= stored_len)
               r.status = ple_pkg::ST_RANGE;
            else
               r.value = stored[pos];
         end
         default: ;
      endcase
      r.len = stored_len[ple_pkg::LengthWidth-1:0];
      return r;
   endfunction

   task automatic check_reply();
      list_reply_type want;
      if (awaited.size() == 0) begin
         $display("%0t: reply with nothing awaited: data %h", $time, rsp_tdata);
         faults++;
      end else begin
         want = awaited.pop_front();
         if (rsp_tdata[31:0] !== want.value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.value,
                     rsp_tdata[31:0]);
            faults++;
         end
         if (rsp_tdata[36:32] !== want.len) begin
            $display("%0t: length expected %0d actual %0d", $time, want.len,
                     rsp_tdata[36:32]);
            faults++;
         end
         if (rsp_tdata[38:37] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_tdata[38:37]);
            faults++;
         end
      end
   endtask

   // Response side: check each accepted item, then stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_reply();
      if (quiet || reset)
         rsp_tready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   task automatic send_item(logic [OpW-1:0] op, logic signed [ple_pkg::ValueWidth-1:0] val,
                            logic [PosW-1:0] pos);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, val, op};
      do @(posedge clock); while (!req_tready);
      awaited.push_back(apply_list_op(op, val, pos));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [ple_pkg::ValueWidth-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_list();
      int k;
      send_item(ple_pkg::OP_READ, 0, 0);
      send_item(ple_pkg::OP_REMOVE, 0, 0);
      send_item(ple_pkg::OP_INSERT, 32'sh1234_5678, 1);
      send_item(ple_pkg::OP_PREPEND, 32'sh0bad_cafe, 0);
      send_item(ple_pkg::OP_READ, 0, 0);
      send_item(ple_pkg::OP_REMOVE, 0, 0);
      for (k = int'(ple_pkg::OP_READ) + 1; k < (1 << OpW); k++)
         send_item(OpW'(k), -1, '1);
   endtask

   task automatic test_extremes();
      send_item(ple_pkg::OP_APPEND, 32'sh7fff_ffff, 0);
      send_item(ple_pkg::OP_APPEND, 32'sh8000_0000, 0);
      send_item(ple_pkg::OP_PREPEND, -1, 0);
      send_item(ple_pkg::OP_INSERT, 0, 1);
      send_item(ple_pkg::OP_INSERT, 32'sh5555_5555, 4);
      send_item(ple_pkg::OP_INSERT, 32'sh2aaa_aaaa, 6);
      send_item(ple_pkg::OP_READ, 0, 0);
      send_item(ple_pkg::OP_READ, 0, 2);
      send_item(ple_pkg::OP_READ, 0, 4);
      send_item(ple_pkg::OP_READ, 0, 5);
      send_item(ple_pkg::OP_READ, 0, '1);
      send_item(ple_pkg::OP_REMOVE, 0, 2);
      send_item(ple_pkg::OP_REMOVE, 0, 0);
      send_item(ple_pkg::OP_REMOVE, 0, 2);
      send_item(ple_pkg::OP_REMOVE, 0, 1);
      send_item(ple_pkg::OP_REMOVE, 0, 0);
   endtask

   // Fill to the brim, bounce off every store operation, then empty it again.
   task automatic test_full_list();
      while (stored_len < Depth)
         send_item(ple_pkg::OP_APPEND, pick_value(), 0);
      send_item(ple_pkg::OP_APPEND, pick_value(), 0);
      send_item(ple_pkg::OP_PREPEND, pick_value(), 0);
      send_item(ple_pkg::OP_INSERT, pick_value(), 0);
      send_item(ple_pkg::OP_INSERT, pick_value(), PosW'(Depth));
      send_item(ple_pkg::OP_INSERT, pick_value(), PosW'(Depth + 1));
      send_item(ple_pkg::OP_READ, 0, PosW'(Depth - 1));
      send_item(ple_pkg::OP_READ, 0, PosW'(Depth));
      send_item(ple_pkg::OP_REMOVE, 0, PosW'(Depth - 1));
      send_item(ple_pkg::OP_INSERT, pick_value(), PosW'(Depth - 1));
      while (stored_len > 0)
         send_item(ple_pkg::OP_REMOVE, 0, PosW'($urandom_range(0, stored_len - 1)));
   endtask

   // Random operations that drift between full and empty so both ends get hit.
   task automatic test_random_mix(int unsigned count);
      int unsigned n;
      int unsigned grow_pct;
      bit          grows;
      logic [OpW-1:0]  op;
      logic [PosW-1:0] pos;
      grow_pct = 60;
      for (n = 0; n < count; n++) begin
         if (stored_len == Depth)
            grow_pct = 30;
         else if (stored_len == 0)
            grow_pct = 70;
         else if ($urandom_range(0, 39) == 0)
            grow_pct = $urandom_range(30, 70);
         grows = 1'b0;
         if ($urandom_range(0, 29) == 0)
            op = OpW'($urandom_range(int'(ple_pkg::OP_READ) + 1, (1 << OpW) - 1));
         else if ($urandom_range(0, 99) < grow_pct) begin
            grows = 1'b1;
            case ($urandom_range(0, 2))
               0: op = ple_pkg::OP_APPEND;
               1: op = ple_pkg::OP_PREPEND;
               default: op = ple_pkg::OP_INSERT;
            endcase
         end else
            op = ($urandom_range(0, 1) == 0) ? ple_pkg::OP_REMOVE : ple_pkg::OP_READ;
         if ($urandom_range(0, 9) == 0)
            pos = PosW'($urandom_range(0, (1 << PosW) - 1));
         else if (grows)
            pos = PosW'($urandom_range(0, stored_len));
         else if (stored_len > 0)
            pos = PosW'($urandom_range(0, stored_len - 1));
         else
            pos = 0;
         send_item(op, pick_value(), pos);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_extremes();
      test_full_list();
      test_random_mix(220);
      wait_for_drain();
      quiet = 1'b1;
      test_random_mix(60);
      quiet = 1'b0;
      test_random_mix(200);
      quiet = 1'b1;
      test_random_mix(100);
      wait_for_drain();
      repeat (DrainWait) @(posedge clock);
      if (faults == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
